// ===== rtl/b64vd_pkg.sv =====
// Package for the base64 variant decoder: request types and alphabet lookup.
package b64vd_pkg;

  localparam int unsigned CharW   = 8;
  localparam int unsigned SextetW = 7;
  localparam int unsigned PhaseW  = 2;

  localparam logic [SextetW-1:0] PadValue   = 7'd64;
  localparam logic [SextetW-1:0] DashValue  = 7'd63;
  localparam logic [SextetW-1:0] PlusValue  = 7'd62;
  localparam logic [SextetW-1:0] DigitBase  = 7'd52;
  localparam logic [SextetW-1:0] LowerBase  = 7'd26;

  localparam logic [CharW-1:0] ChDash  = 8'h2D;
  localparam logic [CharW-1:0] ChPlus  = 8'h2B;
  localparam logic [CharW-1:0] ChZero  = 8'h30;
  localparam logic [CharW-1:0] ChNine  = 8'h39;
  localparam logic [CharW-1:0] ChLowA  = 8'h61;
  localparam logic [CharW-1:0] ChLowZ  = 8'h7A;
  localparam logic [CharW-1:0] ChUpA   = 8'h41;
  localparam logic [CharW-1:0] ChUpZ   = 8'h5A;

  // Position of a character inside its group of four.
  localparam logic [PhaseW-1:0] PhaseFirst  = 2'd0;
  localparam logic [PhaseW-1:0] PhaseSecond = 2'd1;
  localparam logic [PhaseW-1:0] PhaseThird  = 2'd2;
  localparam logic [PhaseW-1:0] PhaseFourth = 2'd3;

  typedef struct packed {
    logic [CharW-1:0] in_char;
    logic             in_last;
  } b64vd_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       out_last;
  } b64vd_out_t;

  // Map a character code to its sextet value; anything else is padding.
  function automatic logic [SextetW-1:0] sextet_of(input logic [CharW-1:0] ch);
    logic [CharW-1:0] diff;
    diff = '0;
    if (ch == ChDash) begin
      return DashValue;
    end else if (ch == ChPlus) begin
      return PlusValue;
    end else if (ch >= ChZero && ch <= ChNine) begin
      diff = ch - ChZero;
      return diff[SextetW-1:0] + DigitBase;
    end else if (ch >= ChLowA && ch <= ChLowZ) begin
      diff = ch - ChLowA;
      return diff[SextetW-1:0] + LowerBase;
    end else if (ch >= ChUpA && ch <= ChUpZ) begin
      diff = ch - ChUpA;
      return diff[SextetW-1:0];
    end
    return PadValue;
  endfunction

endpackage

// ===== rtl/base64_variant_decoder_core.sv =====
// Top level of the base64 variant decoder: group state and output register.
//
//   channel | signals                          | direction | payload
//   --------+----------------------------------+-----------+-------------
//   input   | in_valid_i, in_stall_o, in_data_i | into core | b64vd_in_t
//   output  | out_valid_o, out_stall_i, out_data_o | out     | b64vd_out_t
//
// One character request is taken per cycle unless stalled; its result is
// in the output register the cycle after acceptance. The path is one table
// lookup and a few shifts between the input port and the result register.
// Reset clears the group phase, held sextet, pad flag and output valid.
// in_stall_o rises only while a result is held and the sink stalls; then
// the input waits and no state changes.
module base64_variant_decoder_core
  import b64vd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  b64vd_in_t  in_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output b64vd_out_t out_data_o
);

  logic [PhaseW-1:0]  phase_q, phase_d;
  logic [SextetW-1:0] held_q, held_d;
  logic               pad_seen_q, pad_seen_d;
  logic               out_valid_q, out_valid_d;
  b64vd_out_t         out_data_q, out_data_d;

  logic               accept;
  logic [SextetW-1:0] sextet;
  logic               pad_third;
  logic [7:0]         dec_byte;
  logic               dec_valid;

  b64vd_unpack u_unpack (
    .char_i      (in_data_i.in_char),
    .last_i      (in_data_i.in_last),
    .phase_i     (phase_q),
    .held_i      (held_q),
    .pad_seen_i  (pad_seen_q),
    .sextet_o    (sextet),
    .pad_third_o (pad_third),
    .byte_o      (dec_byte),
    .valid_o     (dec_valid)
  );

  // Hold the input only when the result register is full and not drained.
  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;

  always_comb begin
    phase_d     = phase_q;
    held_d      = held_q;
    pad_seen_d  = pad_seen_q;
    out_valid_d = out_valid_q & out_stall_i;
    out_data_d  = out_data_q;
    if (accept) begin
      // Advance the group position and remember this character's sextet.
      phase_d = phase_q + 2'd1;
      held_d  = sextet;
      if (phase_q == PhaseThird) begin
        pad_seen_d = pad_third;
      end
      // End of stream: start the next stream from a clean group.
      if (in_data_i.in_last) begin
        phase_d    = PhaseFirst;
        held_d     = '0;
        pad_seen_d = 1'b0;
      end
      out_valid_d           = 1'b1;
      out_data_d.out_byte   = dec_byte;
      out_data_d.byte_valid = dec_valid;
      out_data_d.out_last   = in_data_i.in_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhaseFirst;
      held_q      <= '0;
      pad_seen_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      held_q      <= held_d;
      pad_seen_q  <= pad_seen_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload needs no reset; it is qualified by out_valid_q.
  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== rtl/b64vd_unpack.sv =====
// Combinational byte assembly for one character from the group state.
module b64vd_unpack
  import b64vd_pkg::*;
(
  input  logic [CharW-1:0]   char_i,
  input  logic               last_i,
  input  logic [PhaseW-1:0]  phase_i,
  input  logic [SextetW-1:0] held_i,
  input  logic               pad_seen_i,
  output logic [SextetW-1:0] sextet_o,
  output logic               pad_third_o,
  output logic [7:0]         byte_o,
  output logic               valid_o
);

  logic [SextetW-1:0] q;
  logic               is_pad;

  assign q           = sextet_of(char_i);
  assign is_pad      = q[SextetW-1];
  assign sextet_o    = q;
  assign pad_third_o = is_pad;

  always_comb begin
    byte_o  = 8'h00;
    valid_o = 1'b0;
    unique case (phase_i)
      PhaseFirst: begin
        // Missing second character counts as padding.
        if (last_i) begin
          byte_o  = {q[5:0], 2'b00} | 8'h04;
          valid_o = 1'b1;
        end
      end
      PhaseSecond: begin
        byte_o  = {held_i[5:0], 2'b00} | {5'b0, q[6:4]};
        valid_o = 1'b1;
      end
      PhaseThird: begin
        if (!is_pad) begin
          byte_o  = {held_i[3:0], 4'b0000} | {3'b000, q[6:2]};
          valid_o = 1'b1;
        end
      end
      PhaseFourth: begin
        if (!pad_seen_i && !is_pad) begin
          byte_o  = {held_i[1:0], 6'b000000} | {1'b0, q};
          valid_o = 1'b1;
        end
      end
      default: begin
        byte_o  = 8'h00;
        valid_o = 1'b0;
      end
    endcase
  end

endmodule

// ===== rtl/b64vd_checker.sv =====
// Port-level checker for the base64 variant decoder and its bind.
module b64vd_checker
  import b64vd_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input b64vd_in_t  in_data_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input b64vd_out_t out_data_o
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // The input is stalled only by a full, stalled output.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

  // Every accepted request yields a result next cycle carrying its last flag.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o && out_data_o.out_last == $past(in_data_i.in_last))
    else $error("accepted request produced no matching result");

  // No byte released means a zero byte.
  a_zero_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.byte_valid |-> out_data_o.out_byte == 8'h00)
    else $error("byte nonzero without byte_valid");

endmodule

bind base64_variant_decoder_core b64vd_checker u_b64vd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
